// ===== src/twcs_pkg.sv =====
package twcs_pkg;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_SCREEN_WIDTH  = 2'd0,
        CFG_SCREEN_HEIGHT = 2'd1,
        CFG_TEX_WIDTH     = 2'd2,
        CFG_TEX_HEIGHT    = 2'd3
    } t_cfg_idx;

    // Reset values and fixed constants
    localparam logic [11:0] SCREEN_WIDTH_RST  = 12'd640;
    localparam logic [11:0] SCREEN_HEIGHT_RST = 12'd480;
    localparam logic [6:0]  TEX_WIDTH_RST     = 7'd64;
    localparam logic [6:0]  TEX_HEIGHT_RST    = 7'd64;
    localparam int          TEX_DEPTH_DEF     = 4096;
    localparam int          MAX_SCREEN_DEF    = 2048;
    localparam int          SHADE_MAX         = 100;
    localparam logic [15:0] DIST_UNIT         = 16'd256;
    localparam logic [14:0] SHADE_DC_MIN      = 15'd256;
    localparam logic [14:0] SHADE_DC_MAX      = 15'(SHADE_MAX * 256);

    // Payload carried alongside the wall height divider
    typedef struct packed {
        logic        func;
        logic [10:0] column;
        logic [10:0] row;
        logic [15:0] dist_q8;
        logic [7:0]  frac;
        logic [11:0] taddr;
        logic [23:0] tdata;
    } t_side1;

    // Payload carried alongside the texture line divider
    typedef struct packed {
        logic        func;
        logic        on;
        logic [21:0] pix_addr;
        logic [6:0]  col;
        logic [11:0] taddr;
        logic [23:0] tdata;
        logic [15:0] dist_q8;
    } t_side2;

    // Payload carried alongside the shading divider
    typedef struct packed {
        logic        drawn;
        logic [21:0] pix_addr;
    } t_side3;

    // Texture memory access request
    typedef struct packed {
        logic        valid;
        logic        we;
        logic [13:0] idx;
        logic [11:0] taddr;
        logic [23:0] wdata;
    } t_mem_req;

endpackage

// ===== src/twcs_div.sv =====
module twcs_div
    import twcs_pkg::*;
#(
    parameter int LANES  = 1,
    parameter int NUM_W  = 8,
    parameter int DEN_W  = 8,
    parameter int Q_W    = 8,
    parameter int SIDE_W = 1
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  logic [LANES-1:0][NUM_W-1:0]     i_num,
    input  logic [DEN_W-1:0]                i_den,
    input  logic [SIDE_W-1:0]               i_side,
    output logic                            o_valid,
    output logic [LANES-1:0][Q_W-1:0]       o_quo,
    output logic [SIDE_W-1:0]               o_side
);

    localparam int PAD_W = Q_W + DEN_W;

    logic [Q_W-1:0]                r_valid;
    logic [DEN_W-1:0]              r_den  [Q_W];
    logic [SIDE_W-1:0]             r_side [Q_W];
    logic [LANES-1:0][DEN_W-1:0]   r_rem  [Q_W];
    logic [LANES-1:0][Q_W-1:0]     r_acc  [Q_W];

    logic                          a_valid [Q_W+1];
    logic [DEN_W-1:0]              a_den   [Q_W+1];
    logic [SIDE_W-1:0]             a_side  [Q_W+1];
    logic [LANES-1:0][DEN_W-1:0]   a_rem   [Q_W+1];
    logic [LANES-1:0][Q_W-1:0]     a_acc   [Q_W+1];

    // Split each numerator into a starting remainder and the bits still to bring down
    always_comb begin
        logic [PAD_W-1:0] pad;
        a_valid[0] = i_valid;
        a_den[0]   = i_den;
        a_side[0]  = i_side;
        for (int l = 0; l < LANES; l++) begin
            pad         = PAD_W'(i_num[l]);
            a_rem[0][l] = pad[PAD_W-1:Q_W];
            a_acc[0][l] = pad[Q_W-1:0];
        end
    end

    // One quotient bit per stage
    for (genvar s = 0; s < Q_W; s++) begin : g_stage
        logic [LANES-1:0][DEN_W-1:0] n_rem;
        logic [LANES-1:0][Q_W-1:0]   n_acc;

        always_comb begin
            logic [DEN_W:0] trial;
            logic           qbit;
            for (int l = 0; l < LANES; l++) begin
                trial = {a_rem[s][l], a_acc[s][l][Q_W-1]};
                qbit  = (trial >= {1'b0, a_den[s]});
                if (qbit) begin
                    n_rem[l] = DEN_W'(trial - {1'b0, a_den[s]});
                end else begin
                    n_rem[l] = trial[DEN_W-1:0];
                end
                n_acc[l] = {a_acc[s][l][Q_W-2:0], qbit};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else if (i_en) begin
                r_valid[s] <= a_valid[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[s]  <= a_den[s];
                r_side[s] <= a_side[s];
                r_rem[s]  <= n_rem;
                r_acc[s]  <= n_acc;
            end
        end

        assign a_valid[s+1] = r_valid[s];
        assign a_den[s+1]   = r_den[s];
        assign a_side[s+1]  = r_side[s];
        assign a_rem[s+1]   = r_rem[s];
        assign a_acc[s+1]   = r_acc[s];
    end

    assign o_valid = a_valid[Q_W];
    assign o_quo   = a_acc[Q_W];
    assign o_side  = a_side[Q_W];

endmodule

// ===== src/twcs_tex_mem.sv =====
module twcs_tex_mem
    import twcs_pkg::*;
#(
    parameter int TEX_DEPTH = TEX_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_en,
    input  t_mem_req    i_req,
    output logic        o_hit,
    output logic [23:0] o_rd_data
);

    localparam int ADDR_W = (TEX_DEPTH > 1) ? $clog2(TEX_DEPTH) : 1;
    localparam logic [16:0] DEPTH_W = 17'(TEX_DEPTH);

    logic [23:0]       r_mem [TEX_DEPTH];
    logic [23:0]       r_rd_data;
    logic              r_hit;
    logic [16:0]       idx_ext;
    logic [16:0]       taddr_ext;
    logic              rd_ok;
    logic              wr_ok;
    logic [ADDR_W-1:0] addr;

    // Range checks and shared address for load and lookup
    always_comb begin
        idx_ext   = 17'(i_req.idx);
        taddr_ext = 17'(i_req.taddr);
        rd_ok     = (idx_ext < DEPTH_W);
        wr_ok     = (taddr_ext < DEPTH_W);
        addr      = i_req.we ? taddr_ext[ADDR_W-1:0] : idx_ext[ADDR_W-1:0];
    end

    // Write a texel load, read for a pixel lookup
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_req.valid && i_req.we && wr_ok) begin
                r_mem[addr] <= i_req.wdata;
            end
            r_rd_data <= r_mem[addr];
            r_hit     <= rd_ok;
        end
    end

    assign o_hit     = r_hit;
    assign o_rd_data = r_rd_data;

endmodule

// ===== src/textured_wall_column_shader_top.sv =====
// Textured wall column shader.
// Input channel (i_valid / o_stall): each beat is a texel load (i_func = 1)
// or one pixel request (i_func = 0). Output channel (o_valid / i_stall):
// exactly one result beat per input beat, in order. A texel load and a pixel
// off the wall span return drawn = 0 with zero address and colour.
// Configuration (i_cfg_valid / o_cfg_ready, always ready) writes screen and
// texture sizes; write it only while no beat is in flight.
// The pipeline runs through the wall height divider (one quotient bit a
// stage), a span stage, the texture line divider, the texture memory read,
// the shading dividers and the output register. Throughput is one beat
// per cycle unless the receiver stalls; texel loads write the memory at the
// same stage where pixels read it, so loads and lookups keep their order.
// Reset clears the pipeline valid bits and loads the default sizes
// (640 x 480 screen, 64 x 64 texture); texture memory is not cleared.
// When the receiver stalls with a result held, the whole pipeline holds and
// o_stall rises in the same cycle.
module textured_wall_column_shader_top
    import twcs_pkg::*;
#(
    parameter int TEX_DEPTH      = TEX_DEPTH_DEF,
    parameter int MAX_SCREEN_DIM = MAX_SCREEN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_func,
    input  logic [10:0] i_screen_col,
    input  logic [10:0] i_screen_row,
    input  logic [15:0] i_distance,
    input  logic [15:0] i_wall_x,
    input  logic [15:0] i_wall_y,
    input  logic        i_horizontal_hit,
    input  logic [11:0] i_texel_addr,
    input  logic [23:0] i_texel_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_drawn,
    output logic [21:0] o_pixel_addr,
    output logic [23:0] o_color,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  t_cfg_idx    i_cfg_index,
    input  logic [11:0] i_cfg_data
);

    localparam logic [13:0] MAX_DIM = 14'(MAX_SCREEN_DIM);

    logic [11:0] r_cfg_sw;
    logic [11:0] r_cfg_sh;
    logic [6:0]  r_cfg_tw;
    logic [6:0]  r_cfg_th;

    logic        en;
    logic [11:0] sw;
    logic [10:0] half;
    logic [13:0] sw_sat;
    logic [13:0] sh_sat;

    // Configuration writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_sw <= SCREEN_WIDTH_RST;
            r_cfg_sh <= SCREEN_HEIGHT_RST;
            r_cfg_tw <= TEX_WIDTH_RST;
            r_cfg_th <= TEX_HEIGHT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SCREEN_WIDTH:  r_cfg_sw <= i_cfg_data;
                CFG_SCREEN_HEIGHT: r_cfg_sh <= i_cfg_data;
                CFG_TEX_WIDTH:     r_cfg_tw <= i_cfg_data[6:0];
                CFG_TEX_HEIGHT:    r_cfg_th <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // Saturate screen sizes
    always_comb begin
        sw_sat = (14'(r_cfg_sw) > MAX_DIM) ? MAX_DIM : 14'(r_cfg_sw);
        sh_sat = (14'(r_cfg_sh) > MAX_DIM) ? MAX_DIM : 14'(r_cfg_sh);
        sw     = sw_sat[11:0];
        half   = sh_sat[11:1];
    end

    // Advance the whole pipeline unless a held result is stalled
    logic r_out_valid;
    assign en      = !r_out_valid || !i_stall;
    assign o_stall = !en;

    // Wall height divider: wh = half * 256 / distance, zero distance taken as 1
    t_side1      s1_in;
    logic [15:0] dz;
    logic        d1_valid;
    logic [0:0][18:0] d1_quo;
    logic [$bits(t_side1)-1:0] d1_side_raw;
    t_side1      d1_side;

    always_comb begin
        s1_in.func    = i_func;
        s1_in.column  = i_screen_col;
        s1_in.row     = i_screen_row;
        s1_in.dist_q8 = i_distance;
        s1_in.frac    = i_horizontal_hit ? i_wall_x[7:0] : i_wall_y[7:0];
        s1_in.taddr   = i_texel_addr;
        s1_in.tdata   = i_texel_data;
        dz            = (i_distance == 16'd0) ? 16'd1 : i_distance;
    end

    twcs_div #(
        .LANES  (1),
        .NUM_W  (19),
        .DEN_W  (16),
        .Q_W    (19),
        .SIDE_W ($bits(t_side1))
    ) u_div_wh (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_num   ({half, 8'd0}),
        .i_den   (dz),
        .i_side  (s1_in),
        .o_valid (d1_valid),
        .o_quo   (d1_quo),
        .o_side  (d1_side_raw)
    );

    assign d1_side = t_side1'(d1_side_raw);

    // Span test, texture column and framebuffer address
    logic        r_c_valid;
    logic [19:0] r_c_sum;
    logic [19:0] r_c_den;
    t_side2      r_c_side;

    logic [18:0] wh;
    logic [12:0] j;
    logic signed [20:0] j_s;
    logic signed [20:0] wh_s;
    logic signed [20:0] half_s;
    logic signed [20:0] sum_s;
    logic        on;
    logic [14:0] col_prod;
    logic [22:0] pix_full;
    t_side2      n_c_side;

    always_comb begin
        wh       = d1_quo[0];
        j        = 13'({2'b00, d1_side.row}) - 13'({2'b00, half});
        j_s      = $signed({{8{j[12]}}, j});
        wh_s     = $signed({2'b00, wh});
        half_s   = $signed({10'd0, half});
        if (d1_side.dist_q8 > DIST_UNIT) begin
            on = (j_s > -wh_s) && (j_s < wh_s);
        end else begin
            on = (j_s >= -half_s) && (j_s < half_s);
        end
        on       = on && (wh != 19'd0);
        sum_s    = wh_s + j_s;
        col_prod = 15'(d1_side.frac) * 15'(r_cfg_tw);
        pix_full = 23'(d1_side.column) + 23'(d1_side.row) * 23'(sw);

        n_c_side.func     = d1_side.func;
        n_c_side.on       = on;
        n_c_side.pix_addr = pix_full[21:0];
        n_c_side.col      = col_prod[14:8];
        n_c_side.taddr    = d1_side.taddr;
        n_c_side.tdata    = d1_side.tdata;
        n_c_side.dist_q8  = d1_side.dist_q8;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (en) begin
            r_c_valid <= d1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_sum  <= on ? sum_s[19:0] : 20'd0;
            r_c_den  <= {wh, 1'b0};
            r_c_side <= n_c_side;
        end
    end

    // Texture line divider: line = tex_height * (wh + j) / (2 * wh)
    logic [26:0] num2;
    logic        d2_valid;
    logic [0:0][6:0] d2_quo;
    logic [$bits(t_side2)-1:0] d2_side_raw;
    t_side2      d2_side;

    assign num2 = 27'(r_cfg_th) * 27'(r_c_sum);

    twcs_div #(
        .LANES  (1),
        .NUM_W  (27),
        .DEN_W  (20),
        .Q_W    (7),
        .SIDE_W ($bits(t_side2))
    ) u_div_line (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_c_valid),
        .i_num   (num2),
        .i_den   (r_c_den),
        .i_side  (r_c_side),
        .o_valid (d2_valid),
        .o_quo   (d2_quo),
        .o_side  (d2_side_raw)
    );

    assign d2_side = t_side2'(d2_side_raw);

    // Texture memory: load or lookup in order
    t_mem_req    mem_req;
    logic        mem_hit;
    logic [23:0] mem_rd;

    always_comb begin
        mem_req.valid = d2_valid;
        mem_req.we    = d2_side.func;
        mem_req.idx   = 14'(d2_quo[0]) * 14'(r_cfg_tw) + 14'(d2_side.col);
        mem_req.taddr = d2_side.taddr;
        mem_req.wdata = d2_side.tdata;
    end

    twcs_tex_mem #(
        .TEX_DEPTH (TEX_DEPTH)
    ) u_tex_mem (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_req     (mem_req),
        .o_hit     (mem_hit),
        .o_rd_data (mem_rd)
    );

    logic        r_e_valid;
    t_side3      r_e_side;
    logic [15:0] r_e_dist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (en) begin
            r_e_valid <= d2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_side.drawn    <= d2_side.on && !d2_side.func;
            r_e_side.pix_addr <= d2_side.pix_addr;
            r_e_dist          <= d2_side.dist_q8;
        end
    end

    // Shading dividers: channel * 256 / clamped distance
    logic [23:0] texel;
    logic [14:0] dc;
    logic [2:0][15:0] num3;
    logic        d3_valid;
    logic [2:0][7:0] d3_quo;
    logic [$bits(t_side3)-1:0] d3_side_raw;
    t_side3      d3_side;

    always_comb begin
        texel = mem_hit ? mem_rd : 24'd0;
        if (r_e_dist < 16'(SHADE_DC_MIN)) begin
            dc = SHADE_DC_MIN;
        end else if (r_e_dist > 16'(SHADE_DC_MAX)) begin
            dc = SHADE_DC_MAX;
        end else begin
            dc = r_e_dist[14:0];
        end
        num3[2] = {texel[23:16], 8'd0};
        num3[1] = {texel[15:8], 8'd0};
        num3[0] = {texel[7:0], 8'd0};
    end

    twcs_div #(
        .LANES  (3),
        .NUM_W  (16),
        .DEN_W  (15),
        .Q_W    (8),
        .SIDE_W ($bits(t_side3))
    ) u_div_shade (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_e_valid),
        .i_num   (num3),
        .i_den   (dc),
        .i_side  (r_e_side),
        .o_valid (d3_valid),
        .o_quo   (d3_quo),
        .o_side  (d3_side_raw)
    );

    assign d3_side = t_side3'(d3_side_raw);

    // Output register
    logic        r_out_drawn;
    logic [21:0] r_out_addr;
    logic [23:0] r_out_color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= d3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_drawn <= d3_side.drawn;
            r_out_addr  <= d3_side.drawn ? d3_side.pix_addr : 22'd0;
            r_out_color <= d3_side.drawn ? {d3_quo[2], d3_quo[1], d3_quo[0]} : 24'd0;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_drawn      = r_out_drawn;
    assign o_pixel_addr = r_out_addr;
    assign o_color      = r_out_color;

    // Checks
    a_undrawn_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_drawn) |-> (o_color == 24'd0 && o_pixel_addr == 22'd0))
        else $error("undrawn result carries nonzero payload");

    a_stall_only_when_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a held result");

    a_hold_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_e_valid && o_stall) |=> r_e_valid)
        else $error("memory stage lost an item while stalled");

endmodule

// ===== verif/textured_wall_column_shader_top_test.sv =====
module textured_wall_column_shader_top_test
    import twcs_pkg::*;
();

    localparam logic FUNC_RENDER = 1'b0;
    localparam logic FUNC_LOAD   = 1'b1;
    localparam int   PIPE_DRAIN  = 60;
    localparam int   N_RANDOM    = 1026;
    localparam int   FILL_DEPTH  = 256;

    typedef struct {
        logic        func;
        logic [10:0] column;
        logic [10:0] row;
        logic [15:0] dist_q8;
        logic [15:0] wx;
        logic [15:0] wy;
        logic        hhit;
        logic [11:0] taddr;
        logic [23:0] tdata;
    } shader_req_t;

    typedef struct {
        logic        drawn;
        logic [21:0] addr;
        logic [23:0] color;
    } shaded_pixel_t;

    // Column shader predictor with its own texture memory and sizes
    class wall_scoreboard;
        logic [23:0]   tex_mem [TEX_DEPTH_DEF];
        int unsigned   scr_w, scr_h, tex_w, tex_h;
        shaded_pixel_t pending [$];
        int            mismatches, checked, drawn_seen;

        function void reset_sizes();
            scr_w = SCREEN_WIDTH_RST;
            scr_h = SCREEN_HEIGHT_RST;
            tex_w = TEX_WIDTH_RST;
            tex_h = TEX_HEIGHT_RST;
        endfunction

        function void write_size(t_cfg_idx idx, logic [11:0] data);
            case (idx)
                CFG_SCREEN_WIDTH:  scr_w = data;
                CFG_SCREEN_HEIGHT: scr_h = data;
                CFG_TEX_WIDTH:     tex_w = data[6:0];
                CFG_TEX_HEIGHT:    tex_h = data[6:0];
            endcase
        endfunction

        function logic [7:0] darken(logic [7:0] ch, longint dc);
            return 8'((longint'(ch) * 256) / dc);
        endfunction

        // Work out the expected beat for one accepted request
        function void note_request(shader_req_t r);
            shaded_pixel_t e;
            longint sw, half, dz, wh, j, line, idx, dc;
            logic [7:0] frac;
            logic [23:0] texel;
            bit on;
            e = '{1'b0, '0, '0};
            if (r.func == FUNC_LOAD) begin
                tex_mem[r.taddr] = r.tdata;
            end else begin
                sw = scr_w > MAX_SCREEN_DEF ? MAX_SCREEN_DEF : scr_w;
                half = (scr_h > MAX_SCREEN_DEF ? MAX_SCREEN_DEF : scr_h) / 2;
                dz = r.dist_q8 == 0 ? 1 : r.dist_q8;
                wh = (half * 256) / dz;
                j = longint'(r.row) - half;
                if (r.dist_q8 > DIST_UNIT)
                    on = (j > -wh) && (j < wh);
                else
                    on = (j >= -half) && (j < half);
                if (on && wh > 0) begin
                    frac = r.hhit ? r.wx[7:0] : r.wy[7:0];
                    line = (longint'(tex_h) * (wh + j)) / (2 * wh);
                    idx = line * tex_w + ((longint'(frac) * tex_w) >> 8);
                    texel = idx < TEX_DEPTH_DEF ? tex_mem[idx] : '0;
                    dc = r.dist_q8 < 256 ? 256 : (r.dist_q8 > 25600 ? 25600 : r.dist_q8);
                    e.drawn = 1'b1;
                    e.addr = 22'(longint'(r.column) + longint'(r.row) * sw);
                    e.color = {darken(texel[23:16], dc), darken(texel[15:8], dc),
                               darken(texel[7:0], dc)};
                end
            end
            pending.push_back(e);
        endfunction

        // Compare one result beat against the oldest expectation
        function void check_result(logic drawn, logic [21:0] addr, logic [23:0] color);
            shaded_pixel_t e;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat: drawn %0b addr %0d",
                                               drawn, addr);
                return;
            end
            e = pending.pop_front();
            checked++;
            if (drawn) drawn_seen++;
            if (drawn !== e.drawn || addr !== e.addr || color !== e.color) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp drawn %0b addr %0d color %06h, got %0b %0d %06h",
                             e.drawn, e.addr, e.color, drawn, addr, color);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_func = 1'b0;
    logic [10:0] i_screen_col = '0;
    logic [10:0] i_screen_row = '0;
    logic [15:0] i_distance = '0;
    logic [15:0] i_wall_x = '0;
    logic [15:0] i_wall_y = '0;
    logic        i_horizontal_hit = 1'b0;
    logic [11:0] i_texel_addr = '0;
    logic [23:0] i_texel_data = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_drawn;
    logic [21:0] o_pixel_addr;
    logic [23:0] o_color;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    t_cfg_idx    i_cfg_index = CFG_SCREEN_WIDTH;
    logic [11:0] i_cfg_data = '0;

    wall_scoreboard sb = new();
    bit quiet = 1'b0;
    int pixels_sent, loads_sent;

    textured_wall_column_shader_top dut (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #30_000_000;
        $display("textured_wall_column_shader_top_test failed");
        $finish;
    end

    // Receiver: random stall, check each accepted beat
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(o_drawn, o_pixel_addr, o_color);
        i_stall <= i_rst_n && !quiet && ($urandom_range(99) < 23);
    end

    task automatic send(shader_req_t r);
        if (!quiet && $urandom_range(99) < 23) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_func <= r.func;
        i_screen_col <= r.column;
        i_screen_row <= r.row;
        i_distance <= r.dist_q8;
        i_wall_x <= r.wx;
        i_wall_y <= r.wy;
        i_horizontal_hit <= r.hhit;
        i_texel_addr <= r.taddr;
        i_texel_data <= r.tdata;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_request(r);
        if (r.func == FUNC_LOAD) loads_sent++;
        else pixels_sent++;
    endtask

    // Hold off until the pipeline has emptied
    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (PIPE_DRAIN) @(posedge i_clk);
    endtask

    task automatic write_size(t_cfg_idx idx, logic [11:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_size(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_sizes(int sw, int sh, int tw, int th);
        drain();
        write_size(CFG_SCREEN_WIDTH, 12'(sw));
        write_size(CFG_SCREEN_HEIGHT, 12'(sh));
        write_size(CFG_TEX_WIDTH, 12'(tw));
        write_size(CFG_TEX_HEIGHT, 12'(th));
    endtask

    function automatic shader_req_t pixel(int col, int row, int dist_q8, int wx, int wy,
                                          bit hhit);
        shader_req_t r;
        r = '{FUNC_RENDER, 11'(col), 11'(row), 16'(dist_q8), 16'(wx), 16'(wy), hhit,
              12'($urandom), 24'($urandom)};
        return r;
    endfunction

    // Random request: mostly pixels around the wall span, some loads
    function automatic shader_req_t random_req();
        shader_req_t r;
        int half, wh, dist_q8, row;
        r = pixel($urandom, $urandom, $urandom, $urandom, $urandom, $urandom_range(1));
        if ($urandom_range(99) < 20) begin
            r.func = FUNC_LOAD;
            return r;
        end
        case ($urandom_range(2))
            0: dist_q8 = $urandom_range(300);
            1: dist_q8 = $urandom_range(4000);
            default: dist_q8 = $urandom_range(65535);
        endcase
        r.dist_q8 = 16'(dist_q8);
        half = (sb.scr_h > MAX_SCREEN_DEF ? MAX_SCREEN_DEF : sb.scr_h) / 2;
        wh = (half * 256) / (dist_q8 == 0 ? 1 : dist_q8);
        if (wh > half) wh = half;
        if ($urandom_range(99) < 70) begin
            row = half - wh - 2 + $urandom_range(2 * wh + 4);
            if (row < 0) row = 0;
            if (row > 2047) row = 2047;
            r.row = 11'(row);
        end
        return r;
    endfunction

    initial begin
        shader_req_t r;
        int tw;
        sb.reset_sizes();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Fill the low texels; every texture size below keeps lookups inside them
        for (int a = 0; a < FILL_DEPTH; a++) begin
            r = pixel(0, 0, 0, 0, 0, 0);
            r.func = FUNC_LOAD;
            r.taddr = 12'(a);
            r.tdata = a == 0 ? 24'hFFFFFF : (a == 1 ? 24'h000000 : 24'($urandom));
            send(r);
        end
        set_sizes(640, 480, 16, 16);

        // Directed: distance, row and coordinate extremes at the default screen
        send(pixel(0, 240, 0, 0, 0, 0));
        send(pixel(2047, 0, 0, 16'hFFFF, 0, 1));
        send(pixel(5, 239, 1, 0, 16'hFFFF, 0));
        send(pixel(5, 479, 256, 16'h00FF, 0, 1));
        send(pixel(5, 480, 256, 0, 16'h0080, 0));
        send(pixel(9, 240, 257, 16'h1234, 0, 1));
        send(pixel(9, 1, 257, 0, 0, 1));
        send(pixel(9, 240, 25600, 0, 0, 0));
        send(pixel(9, 240, 25601, 0, 0, 0));
        send(pixel(9, 240, 65535, 16'hFFFF, 16'hFFFF, 1));
        send(pixel(9, 2047, 300, 0, 0, 1));
        send(pixel(2047, 2047, 0, 0, 0, 0));
        r = pixel(0, 0, 0, 0, 0, 0);
        r.func = FUNC_LOAD;
        r.taddr = 12'hFFF;
        r.tdata = 24'h00FF00;
        send(r);
        send(pixel(3, 240, 128, 16'hFFFF, 16'hFFFF, 0));

        // Random phases over several size settings, extremes among them
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: ;
                1: set_sizes(2048, 2048, 1, 1);
                2: set_sizes(1, 2, 64, 4);
                3: set_sizes(2048, 3, 64, 1);
                4: set_sizes(333, 123, 37, 6);
                default: begin
                    tw = $urandom_range(1, 64);
                    set_sizes($urandom_range(1, 2048), $urandom_range(2, 2048), tw,
                              $urandom_range(1, (FILL_DEPTH / tw) > 64 ? 64
                                                                       : FILL_DEPTH / tw));
                end
            endcase
            if (p == 0) begin
                // No directed requests are sent in this branch
            end
            quiet = (p == 2);
            for (int n = 0; n < N_RANDOM / 6; n++) send(random_req());
            quiet = 1'b0;
        end

        drain();
        $display("covered %0d pixel requests and %0d texel loads, %0d results checked (%0d drawn)",
                 pixels_sent, loads_sent, sb.checked, sb.drawn_seen);
        $display("mismatches: %0d", sb.mismatches);
        if (sb.mismatches == 0)
            $display("textured_wall_column_shader_top_test passed");
        else
            $display("textured_wall_column_shader_top_test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
src/twcs_pkg.sv
src/twcs_div.sv
src/twcs_tex_mem.sv
src/textured_wall_column_shader_top.sv
verif/textured_wall_column_shader_top_test.sv
